// File: rtl/core/swnm_pkg.sv
// Shared types, constants and state codes for the sliding window negative miner.
`default_nettype none
package swnm_pkg;

    localparam int COORD_W      = 12;
    localparam int THR_W        = 13;
    localparam int MAX_RECTS    = 16;
    localparam int MAX_WINDOWS  = 31;
    localparam int RECT_IDX_W   = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int RECT_CNT_W   = $clog2(MAX_RECTS + 1);
    localparam int WIN_CNT_W    = $clog2(MAX_WINDOWS + 1);
    localparam int AREA_W       = 2 * COORD_W;
    localparam int FRAC_W       = 16;
    localparam int QUO_W        = FRAC_W + 1;
    localparam int SUM_W        = QUO_W + RECT_CNT_W;
    localparam int THR_FRAC_W   = 8;
    localparam int LIMIT_W      = THR_W + THR_FRAC_W;
    localparam int DIV_CNT_W    = $clog2(FRAC_W + 1);

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_W        = THR_W;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_THR  = 2'd2;

    localparam logic [COORD_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [COORD_W-1:0] RST_IMAGE_HEIGHT = 12'd480;
    localparam logic [THR_W-1:0]   RST_OVERLAP_THR  = 13'd77;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
    } box_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_SQUARE,
        ST_WIN,
        ST_READ,
        ST_OVERLAP,
        ST_MUL_INTER,
        ST_MUL_AREA,
        ST_DIV,
        ST_DIV_WAIT,
        ST_ACCUM,
        ST_COMPARE,
        ST_NEXT,
        ST_FINISH
    } state_t;

endpackage
`default_nettype wire

// File: rtl/core/swnm_ifs.sv
// Valid/ready channel interfaces for box beats and window beats.
`default_nettype none
interface swnm_box_if;
    logic                        valid;
    logic                        ready;
    logic [swnm_pkg::COORD_W-1:0] box_x;
    logic [swnm_pkg::COORD_W-1:0] box_y;
    logic [swnm_pkg::COORD_W-1:0] box_width;
    logic [swnm_pkg::COORD_W-1:0] box_height;
    logic                        last_box;

    modport source (output valid, box_x, box_y, box_width, box_height, last_box,
                    input ready);
    modport sink   (input valid, box_x, box_y, box_width, box_height, last_box,
                    output ready);
endinterface

interface swnm_win_if;
    logic                        valid;
    logic                        ready;
    logic                        window_valid;
    logic [swnm_pkg::COORD_W-1:0] window_x;
    logic [swnm_pkg::COORD_W-1:0] window_y;
    logic [swnm_pkg::COORD_W-1:0] window_side;
    logic                        last_window;

    modport source (output valid, window_valid, window_x, window_y, window_side,
                    last_window, input ready);
    modport sink   (input valid, window_valid, window_x, window_y, window_side,
                    last_window, output ready);
endinterface
`default_nettype wire

// File: rtl/core/swnm_box_ram.sv
// Box store: one write port, one registered read port.
`default_nettype none
module swnm_box_ram (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [swnm_pkg::RECT_IDX_W-1:0] waddr,
    input  wire swnm_pkg::box_t                wdata,
    input  wire logic                          re,
    input  wire logic [swnm_pkg::RECT_IDX_W-1:0] raddr,
    output      swnm_pkg::box_t                rdata
);
    import swnm_pkg::*;

    box_t mem [MAX_RECTS];
    box_t rdata_reg;

    // Write a box, register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// File: rtl/core/swnm_div.sv
// Radix-2 fraction divider: floor(num * 2^16 / den) for num <= den, one bit a cycle.
`default_nettype none
module swnm_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [swnm_pkg::AREA_W-1:0] num,
    input  wire logic [swnm_pkg::AREA_W-1:0] den,
    output      swnm_pkg::div_status_t       status,
    output      logic [swnm_pkg::QUO_W-1:0]  quotient
);
    import swnm_pkg::*;

    logic [AREA_W:0]    rem_reg, rem_next;
    logic [AREA_W-1:0]  den_reg, den_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [AREA_W:0]    shifted;
    logic               bit_q;
    logic               int_bit;

    // Load on start, then shift and subtract once a cycle
    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[AREA_W-1:0], 1'b0};
        bit_q     = (shifted >= {1'b0, den_reg});
        int_bit   = (num >= den);
        if (start)
        begin
            den_next  = den;
            quo_next  = {{(QUO_W-1){1'b0}}, int_bit};
            rem_next  = {1'b0, int_bit ? (num - den) : num};
            cnt_next  = DIV_CNT_W'(FRAC_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = bit_q ? (shifted - {1'b0, den_reg}) : shifted;
            quo_next = {quo_reg[QUO_W-2:0], bit_q};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
endmodule
`default_nettype wire

// File: rtl/core/sliding_window_negative_miner_core.sv
// Top level: box collection, window scan sequencer, shared multiplier and divider.
//
//  channel   dir  handshake      payload
//  box_in    in   valid/ready    box_x box_y box_width box_height last_box
//  win_out   out  valid/ready    window_valid window_x window_y window_side last_window
//  cfg       in   cfg_we         cfg_index cfg_wdata (no read-back)
//
// A box beat is taken while the core is idle. A last beat starts the scan,
// during which box_in is held not ready. Each window reads every stored box
// and runs the bit-serial divider for every box it overlaps; the one shared
// multiplier and the divider set the scan's pace. Reset restores the
// register defaults and empties the box set; win_out stalls simply hold
// the scan before the next beat is loaded.
`default_nettype none
module sliding_window_negative_miner_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [swnm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [swnm_pkg::CFG_W-1:0]    cfg_wdata,
    swnm_box_if.sink                           box_in,
    swnm_win_if.source                         win_out
);
    import swnm_pkg::*;

    state_t state_reg, state_next;

    logic [COORD_W-1:0]    img_w_reg, img_h_reg;
    logic [THR_W-1:0]      thr_reg;
    logic [RECT_CNT_W-1:0] count_reg;
    logic [COORD_W-1:0]    widest_reg;
    logic                  zero_reg;
    logic [COORD_W-1:0]    x_reg, y_reg;
    logic [RECT_CNT_W-1:0] idx_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [AREA_W-1:0]     warea_reg, marea_reg, inter_reg;
    logic [COORD_W-1:0]    ox_reg, oy_reg;
    logic [WIN_CNT_W-1:0]  n_reg;
    logic                  pend_reg;
    logic [COORD_W-1:0]    pend_x_reg, pend_y_reg;
    logic                  ovalid_reg, o_wv_reg, o_last_reg;
    logic [COORD_W-1:0]    o_x_reg, o_y_reg, o_side_reg;

    logic                  in_ready, accept, store_ok, out_free, hit;
    logic                  ram_re, div_start;
    logic [RECT_IDX_W-1:0] ram_addr;
    box_t                  wbox, rbox;
    div_status_t           div_st;
    logic [QUO_W-1:0]      div_q;
    logic [COORD_W-1:0]    mul_a, mul_b;
    logic [AREA_W-1:0]     mul_p;
    logic [COORD_W:0]      lo_x, hi_x, lo_y, hi_y, bx2, by2, wx2, wy2;
    logic [COORD_W+1:0]    ny_end, nx_end;
    logic [COORD_W:0]      ny, nx;
    logic                  more_y, more_x, room;

    assign wbox = '{x: box_in.box_x, y: box_in.box_y,
                    w: box_in.box_width, h: box_in.box_height};

    swnm_box_ram u_ram (
        .clk   (clk),
        .we    (accept && store_ok),
        .waddr (count_reg[RECT_IDX_W-1:0]),
        .wdata (wbox),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (rbox)
    );

    swnm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (inter_reg),
        .den      (marea_reg),
        .status   (div_st),
        .quotient (div_q)
    );

    // Shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_SQUARE:    begin mul_a = widest_reg; mul_b = widest_reg; end
            ST_MUL_INTER: begin mul_a = ox_reg;     mul_b = oy_reg;     end
            default:      begin mul_a = rbox.w;     mul_b = rbox.h;     end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Overlap extents of the current box with the current window
    always_comb
    begin
        bx2  = {1'b0, rbox.x} + {1'b0, rbox.w};
        by2  = {1'b0, rbox.y} + {1'b0, rbox.h};
        wx2  = {1'b0, x_reg} + {1'b0, widest_reg};
        wy2  = {1'b0, y_reg} + {1'b0, widest_reg};
        lo_x = (rbox.x > x_reg) ? {1'b0, rbox.x} : {1'b0, x_reg};
        lo_y = (rbox.y > y_reg) ? {1'b0, rbox.y} : {1'b0, y_reg};
        hi_x = (bx2 < wx2) ? bx2 : wx2;
        hi_y = (by2 < wy2) ? by2 : wy2;
    end

    // Window stepping
    always_comb
    begin
        ny     = {1'b0, y_reg} + {1'b0, widest_reg};
        nx     = {1'b0, x_reg} + {1'b0, widest_reg};
        ny_end = {1'b0, ny} + {2'b0, widest_reg};
        nx_end = {1'b0, nx} + {2'b0, widest_reg};
        more_y = ny_end < {2'b0, img_h_reg};
        more_x = nx_end < {2'b0, img_w_reg};
        room   = n_reg < WIN_CNT_W'(MAX_WINDOWS);
    end

    // Handshake and strobe outputs
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        accept    = box_in.valid && in_ready;
        store_ok  = count_reg < RECT_CNT_W'(MAX_RECTS);
        out_free  = !ovalid_reg || win_out.ready;
        ram_re    = (state_reg == ST_READ);
        ram_addr  = idx_reg[RECT_IDX_W-1:0];
        div_start = (state_reg == ST_DIV) && (inter_reg != '0);
        hit       = sum_reg <= SUM_W'({thr_reg, {THR_FRAC_W{1'b0}}});
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && box_in.last_box)
                    state_next = ST_START;
            ST_START:
                if (widest_reg == '0 || zero_reg || !(widest_reg < img_w_reg)
                    || !(widest_reg < img_h_reg))
                    state_next = ST_FINISH;
                else
                    state_next = ST_SQUARE;
            ST_SQUARE:    state_next = ST_WIN;
            ST_WIN:       state_next = ST_READ;
            ST_READ:      state_next = ST_OVERLAP;
            ST_OVERLAP:   state_next = ST_MUL_INTER;
            ST_MUL_INTER: state_next = ST_MUL_AREA;
            ST_MUL_AREA:  state_next = ST_DIV;
            ST_DIV:
                state_next = (inter_reg == '0) ? ST_ACCUM : ST_DIV_WAIT;
            ST_DIV_WAIT:
                if (div_st.done)
                    state_next = ST_ACCUM;
            ST_ACCUM:
                state_next = (idx_reg + 1'b1 == count_reg) ? ST_COMPARE : ST_READ;
            ST_COMPARE:
                if (!hit || !pend_reg || out_free)
                    state_next = ST_NEXT;
            ST_NEXT:
                if (room && (more_y || more_x))
                    state_next = ST_WIN;
                else
                    state_next = ST_FINISH;
            ST_FINISH:
                if (out_free)
                    state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            img_w_reg  <= RST_IMAGE_WIDTH;
            img_h_reg  <= RST_IMAGE_HEIGHT;
            thr_reg    <= RST_OVERLAP_THR;
            count_reg  <= '0;
            widest_reg <= '0;
            zero_reg   <= 1'b0;
            pend_reg   <= 1'b0;
            n_reg      <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Take register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  img_w_reg <= cfg_wdata[COORD_W-1:0];
                    REG_IMAGE_HEIGHT: img_h_reg <= cfg_wdata[COORD_W-1:0];
                    REG_OVERLAP_THR:  thr_reg   <= cfg_wdata;
                    default:          ;
                endcase
            end

            // Collect a box
            if (accept && store_ok)
            begin
                count_reg <= count_reg + 1'b1;
                if (box_in.box_width > widest_reg)
                    widest_reg <= box_in.box_width;
                if (box_in.box_width == '0 || box_in.box_height == '0)
                    zero_reg <= 1'b1;
            end

            if (state_reg == ST_START)
            begin
                n_reg    <= '0;
                pend_reg <= 1'b0;
            end

            // Accept a window, flush the previous one
            if (state_reg == ST_COMPARE && hit && (!pend_reg || out_free))
            begin
                pend_reg <= 1'b1;
                n_reg    <= n_reg + 1'b1;
            end

            if (ovalid_reg && win_out.ready)
                ovalid_reg <= 1'b0;
            if ((state_reg == ST_COMPARE && hit && pend_reg && out_free)
                || (state_reg == ST_FINISH && out_free))
                ovalid_reg <= 1'b1;

            // Drop the box set once the scan is closed
            if (state_reg == ST_FINISH && out_free)
            begin
                count_reg  <= '0;
                widest_reg <= '0;
                zero_reg   <= 1'b0;
                pend_reg   <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_START:
            begin
                x_reg <= '0;
                y_reg <= '0;
            end
            ST_SQUARE:   warea_reg <= mul_p;
            ST_WIN:
            begin
                sum_reg <= '0;
                idx_reg <= '0;
            end
            ST_OVERLAP:
            begin
                ox_reg <= (hi_x > lo_x) ? COORD_W'(hi_x - lo_x) : '0;
                oy_reg <= (hi_y > lo_y) ? COORD_W'(hi_y - lo_y) : '0;
            end
            ST_MUL_INTER: inter_reg <= mul_p;
            ST_MUL_AREA:  marea_reg <= (mul_p < warea_reg) ? mul_p : warea_reg;
            ST_ACCUM:
            begin
                sum_reg <= sum_reg + ((inter_reg == '0) ? '0 : SUM_W'(div_q));
                idx_reg <= idx_reg + 1'b1;
            end
            ST_NEXT:
                if (more_y)
                    y_reg <= ny[COORD_W-1:0];
                else
                begin
                    x_reg <= nx[COORD_W-1:0];
                    y_reg <= '0;
                end
            default: ;
        endcase

        if (state_reg == ST_COMPARE && hit && (!pend_reg || out_free))
        begin
            pend_x_reg <= x_reg;
            pend_y_reg <= y_reg;
        end

        // Load the output beat
        if (state_reg == ST_COMPARE && hit && pend_reg && out_free)
        begin
            o_wv_reg   <= 1'b1;
            o_x_reg    <= pend_x_reg;
            o_y_reg    <= pend_y_reg;
            o_side_reg <= widest_reg;
            o_last_reg <= 1'b0;
        end
        else if (state_reg == ST_FINISH && out_free)
        begin
            o_wv_reg   <= pend_reg;
            o_x_reg    <= pend_reg ? pend_x_reg : '0;
            o_y_reg    <= pend_reg ? pend_y_reg : '0;
            o_side_reg <= pend_reg ? widest_reg : '0;
            o_last_reg <= 1'b1;
        end
    end

    assign box_in.ready         = in_ready;
    assign win_out.valid        = ovalid_reg;
    assign win_out.window_valid = o_wv_reg;
    assign win_out.window_x     = o_x_reg;
    assign win_out.window_y     = o_y_reg;
    assign win_out.window_side  = o_side_reg;
    assign win_out.last_window  = o_last_reg;
endmodule
`default_nettype wire
